[sv/dnfa_pkg.sv]
`default_nettype none

package dnfa_pkg;

   localparam int CNT_W   = 9;
   localparam int ID_W    = 8;
   localparam int FRAME_W = 40;

   typedef enum logic [1:0] {
      ACT_ALLOC      = 2'd0,
      ACT_RELEASE    = 2'd1,
      ACT_FIND_ID    = 2'd2,
      ACT_FIND_FRAME = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_FULL     = 3'd1,
      ST_KIND     = 3'd2,
      ST_NOTFOUND = 3'd3,
      ST_INVALID  = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      RES_FULL,
      RES_KIND,
      RES_INVALID,
      RES_NOTFOUND,
      RES_ALLOC_OK,
      RES_ID_OK,
      RES_FRAME_OK
   } res_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECIDE,
      S_ALLOC_SCAN,
      S_ID_WAIT,
      S_FRAME_SCAN,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic    latch;
      logic    alloc_init;
      logic    alloc_step;
      logic    fr_init;
      logic    fr_step;
      logic    capture;
      res_type res;
      logic    emit;
   } cmd_type;

   typedef struct packed {
      action_type action;
      logic       free_zero;
      logic       kind_ok;
      logic       id_invalid;
      logic       id_used;
      logic       alloc_free;
      logic       alloc_last;
      logic       fr_hit;
      logic       fr_done;
      logic       rsp_free;
   } sts_type;

endpackage

`default_nettype wire

[sv/dnfa_ctrl.sv]
`default_nettype none

module dnfa_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   output dnfa_pkg::cmd_type     cmd,
   input  wire dnfa_pkg::sts_type sts
);
   import dnfa_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            unique case (sts.action) inside
               ACT_ALLOC: begin
                  if (sts.free_zero || !sts.kind_ok) begin
                     state_in = S_FINISH;
                  end else begin
                     state_in = S_ALLOC_SCAN;
                  end
               end
               ACT_RELEASE, ACT_FIND_ID: begin
                  if (sts.id_invalid || !sts.id_used) begin
                     state_in = S_FINISH;
                  end else begin
                     state_in = S_ID_WAIT;
                  end
               end
               default: begin
                  state_in = S_FRAME_SCAN;
               end
            endcase
         end
         S_ALLOC_SCAN: begin
            if (sts.alloc_free || sts.alloc_last) begin
               state_in = S_FINISH;
            end
         end
         S_ID_WAIT: begin
            state_in = S_FINISH;
         end
         S_FRAME_SCAN: begin
            if (sts.fr_hit || sts.fr_done) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (sts.rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      cmd.res   = RES_FULL;
      req_stall = (state_ff != S_IDLE);
      unique case (state_ff)
         S_IDLE: begin
            cmd.latch = req_valid;
         end
         S_DECIDE: begin
            unique case (sts.action) inside
               ACT_ALLOC: begin
                  if (sts.free_zero) begin
                     cmd.capture = 1'b1;
                     cmd.res     = RES_FULL;
                  end else if (!sts.kind_ok) begin
                     cmd.capture = 1'b1;
                     cmd.res     = RES_KIND;
                  end else begin
                     cmd.alloc_init = 1'b1;
                  end
               end
               ACT_RELEASE, ACT_FIND_ID: begin
                  if (sts.id_invalid) begin
                     cmd.capture = 1'b1;
                     cmd.res     = RES_INVALID;
                  end else if (!sts.id_used) begin
                     cmd.capture = 1'b1;
                     cmd.res     = RES_NOTFOUND;
                  end
               end
               default: begin
                  cmd.fr_init = 1'b1;
               end
            endcase
         end
         S_ALLOC_SCAN: begin
            if (sts.alloc_free) begin
               cmd.capture = 1'b1;
               cmd.res     = RES_ALLOC_OK;
            end else if (sts.alloc_last) begin
               cmd.capture = 1'b1;
               cmd.res     = RES_FULL;
            end else begin
               cmd.alloc_step = 1'b1;
            end
         end
         S_ID_WAIT: begin
            cmd.capture = 1'b1;
            cmd.res     = RES_ID_OK;
         end
         S_FRAME_SCAN: begin
            cmd.fr_step = 1'b1;
            if (sts.fr_hit) begin
               cmd.capture = 1'b1;
               cmd.res     = RES_FRAME_OK;
            end else if (sts.fr_done) begin
               cmd.capture = 1'b1;
               cmd.res     = RES_NOTFOUND;
            end
         end
         S_FINISH: begin
            cmd.emit = sts.rsp_free;
         end
         default: begin
            cmd.emit = 1'b0;
         end
      endcase
   end

endmodule

`default_nettype wire

[sv/dnfa_dp.sv]
`default_nettype none

module dnfa_dp #(
   parameter int MAX_SLOTS = 256
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_wr_en,
   input  wire logic [dnfa_pkg::CNT_W-1:0]     csr_wr_data,
   input  wire logic [1:0]                     req_action,
   input  wire logic [dnfa_pkg::ID_W-1:0]      req_slot_id,
   input  wire logic [dnfa_pkg::FRAME_W-1:0]   req_root_frame,
   input  wire logic                           req_root_kind_ok,
   input  wire logic                           rsp_stall,
   output logic                                rsp_valid,
   output logic [2:0]                          rsp_status,
   output logic [dnfa_pkg::ID_W-1:0]           rsp_domain_id,
   output logic [dnfa_pkg::FRAME_W-1:0]        rsp_found_frame,
   input  wire dnfa_pkg::cmd_type              cmd,
   output dnfa_pkg::sts_type                   sts
);
   import dnfa_pkg::*;

   // The 9-bit count register can never select more than 511 slots.
   localparam int EFF   = (MAX_SLOTS > 511) ? 511 : MAX_SLOTS;
   localparam int IDX_W = $clog2(EFF);
   localparam logic [CNT_W-1:0] EFF_CNT = CNT_W'(EFF);
   localparam logic [CNT_W-1:0] RST_CNT = (EFF < 256) ? EFF_CNT : CNT_W'(256);

   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   free_ff;
   logic [IDX_W-1:0]   next_ff;
   logic [EFF-1:0]     used_ff;
   logic [FRAME_W-1:0] frame_mem [EFF];
   logic [FRAME_W-1:0] mem_q_ff;

   action_type         act_ff;
   logic [ID_W-1:0]    id_ff;
   logic [FRAME_W-1:0] frame_ff;
   logic               kind_ff;

   logic [IDX_W-1:0]   cursor_ff;
   logic [CNT_W-1:0]   iter_ff;
   logic               issuing_ff;
   logic               rd_vld_ff;
   logic [IDX_W-1:0]   rd_idx_ff;

   status_type         res_status_ff;
   logic [ID_W-1:0]    res_id_ff;
   logic [FRAME_W-1:0] res_frame_ff;
   logic               rsp_valid_ff;
   status_type         rsp_status_ff;
   logic [ID_W-1:0]    rsp_id_ff;
   logic [FRAME_W-1:0] rsp_frame_ff;

   logic [CNT_W-1:0]   cfg_cnt_in;
   logic [CNT_W-1:0]   last_idx;
   logic [IDX_W-1:0]   id_idx;
   logic               cur_last;
   logic [IDX_W-1:0]   cursor_in;
   logic [IDX_W-1:0]   rd_addr;
   logic               do_alloc;
   logic               do_release;

   assign cfg_cnt_in = (csr_wr_data == '0) ? CNT_W'(1) :
                       ((csr_wr_data > EFF_CNT) ? EFF_CNT : csr_wr_data);
   assign last_idx   = count_ff - CNT_W'(1);
   assign id_idx     = IDX_W'(id_ff);
   assign cur_last   = (CNT_W'(cursor_ff) == last_idx);
   assign cursor_in  = cur_last ? '0 : cursor_ff + IDX_W'(1);
   assign rd_addr    = cmd.fr_step ? cursor_ff : id_idx;
   assign do_alloc   = cmd.capture && (cmd.res == RES_ALLOC_OK);
   assign do_release = cmd.capture && (cmd.res == RES_ID_OK) && (act_ff == ACT_RELEASE);

   always_comb begin
      sts.action     = act_ff;
      sts.free_zero  = (free_ff == '0);
      sts.kind_ok    = kind_ff;
      sts.id_invalid = (id_ff == '0) || ({1'b0, id_ff} >= count_ff);
      sts.id_used    = used_ff[id_idx];
      sts.alloc_free = !used_ff[cursor_ff];
      sts.alloc_last = (iter_ff == last_idx);
      sts.fr_hit     = rd_vld_ff && used_ff[rd_idx_ff] && (mem_q_ff == frame_ff);
      sts.fr_done    = !issuing_ff && !rd_vld_ff;
      sts.rsp_free   = !rsp_valid_ff || !rsp_stall;
   end

   // Table bookkeeping; a count write starts the table afresh.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= RST_CNT;
         free_ff  <= RST_CNT - CNT_W'(1);
         next_ff  <= (RST_CNT == CNT_W'(1)) ? '0 : IDX_W'(1);
         used_ff  <= EFF'(1);
      end else if (csr_wr_en) begin
         count_ff <= cfg_cnt_in;
         free_ff  <= cfg_cnt_in - CNT_W'(1);
         next_ff  <= (cfg_cnt_in == CNT_W'(1)) ? '0 : IDX_W'(1);
         used_ff  <= EFF'(1);
      end else if (do_alloc) begin
         used_ff[cursor_ff] <= 1'b1;
         free_ff            <= free_ff - CNT_W'(1);
         next_ff            <= cursor_in;
      end else if (do_release) begin
         used_ff[id_idx] <= 1'b0;
         free_ff         <= free_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_alloc) begin
         frame_mem[cursor_ff] <= frame_ff;
      end
      mem_q_ff <= frame_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         act_ff   <= action_type'(req_action);
         id_ff    <= req_slot_id;
         frame_ff <= req_root_frame;
         kind_ff  <= req_root_kind_ok;
      end
   end

   // Shared cursor: circular walk for allocation, linear walk from slot 1 for
   // the frame search, whose memory reads are registered before the compare.
   always_ff @(posedge clock) begin
      if (reset) begin
         issuing_ff <= 1'b0;
         rd_vld_ff  <= 1'b0;
      end else if (cmd.alloc_init) begin
         cursor_ff <= next_ff;
         iter_ff   <= '0;
      end else if (cmd.alloc_step) begin
         cursor_ff <= cursor_in;
         iter_ff   <= iter_ff + CNT_W'(1);
      end else if (cmd.fr_init) begin
         cursor_ff  <= IDX_W'(1);
         issuing_ff <= (count_ff > CNT_W'(1));
         rd_vld_ff  <= 1'b0;
      end else if (cmd.fr_step) begin
         rd_vld_ff <= issuing_ff;
         rd_idx_ff <= cursor_ff;
         if (issuing_ff) begin
            if (cur_last) begin
               issuing_ff <= 1'b0;
            end else begin
               cursor_ff <= cursor_ff + IDX_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         unique case (cmd.res)
            RES_ALLOC_OK: begin
               res_status_ff <= ST_OK;
               res_id_ff     <= ID_W'(cursor_ff);
               res_frame_ff  <= frame_ff;
            end
            RES_ID_OK: begin
               res_status_ff <= ST_OK;
               res_id_ff     <= id_ff;
               res_frame_ff  <= mem_q_ff;
            end
            RES_FRAME_OK: begin
               res_status_ff <= ST_OK;
               res_id_ff     <= ID_W'(rd_idx_ff);
               res_frame_ff  <= frame_ff;
            end
            RES_KIND: begin
               res_status_ff <= ST_KIND;
               res_id_ff     <= '0;
               res_frame_ff  <= '0;
            end
            RES_INVALID: begin
               res_status_ff <= ST_INVALID;
               res_id_ff     <= '0;
               res_frame_ff  <= '0;
            end
            RES_NOTFOUND: begin
               res_status_ff <= ST_NOTFOUND;
               res_id_ff     <= '0;
               res_frame_ff  <= '0;
            end
            default: begin
               res_status_ff <= ST_FULL;
               res_id_ff     <= '0;
               res_frame_ff  <= '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_status_ff <= res_status_ff;
         rsp_id_ff     <= res_id_ff;
         rsp_frame_ff  <= res_frame_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_domain_id   = rsp_id_ff;
   assign rsp_found_frame = rsp_frame_ff;

endmodule

`default_nettype wire

[sv/domain_id_next_fit_allocator_core.sv]
// One request at a time; a new request is taken once the previous one has been
// placed in the response register (a waiting response does not block it).
// Release and find by identifier pass through decide, a memory-read wait and finish; refused, decide to finish.
// Allocate walks up to slot_count slots from the next-fit slot; refused in decide if none free or wrong kind.
// Find by root frame reads one slot per cycle, from slot 1 up to slot_count - 1.
// Synchronous reset: 256 slots (clamped to MAX_SLOTS), slot 0 in use, next 1.
`default_nettype none

module domain_id_next_fit_allocator_core #(
   parameter int MAX_SLOTS = 256
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         csr_wr_en,
   input  wire logic [dnfa_pkg::CNT_W-1:0]   csr_wr_data,
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic [1:0]                   req_action,
   input  wire logic [dnfa_pkg::ID_W-1:0]    req_slot_id,
   input  wire logic [dnfa_pkg::FRAME_W-1:0] req_root_frame,
   input  wire logic                         req_root_kind_ok,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output logic [2:0]                        rsp_status,
   output logic [dnfa_pkg::ID_W-1:0]         rsp_domain_id,
   output logic [dnfa_pkg::FRAME_W-1:0]      rsp_found_frame
);
   import dnfa_pkg::*;

   cmd_type cmd;
   sts_type sts;

   dnfa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   dnfa_dp #(
      .MAX_SLOTS (MAX_SLOTS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_action       (req_action),
      .req_slot_id      (req_slot_id),
      .req_root_frame   (req_root_frame),
      .req_root_kind_ok (req_root_kind_ok),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_domain_id    (rsp_domain_id),
      .rsp_found_frame  (rsp_found_frame),
      .cmd              (cmd),
      .sts              (sts)
   );

endmodule

`default_nettype wire
